FILE: sv/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Types and constants shared by the in-place Laplacian smoother modules.
// ----------------------------------------------------------------------------
package lis_pkg;

  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned CFG_DATA_W  = 17;

  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTH_WEIGHT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PASS_COUNT    = 8'd1;

  localparam logic [16:0] WEIGHT_FULL  = 17'd65536;
  localparam logic [16:0] WEIGHT_RESET = 17'd32768;
  localparam logic [3:0]  PASS_RESET   = 4'd1;

  // fewest entries that have an interior to smooth
  localparam int unsigned MIN_SMOOTH_LEN = 3;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_P_RD0,
    ST_P_RD1,
    ST_P_CAP,
    ST_RD,
    ST_DIF,
    ST_MUL,
    ST_WR,
    ST_E_RD,
    ST_E_WAIT
  } state_t;

  typedef enum logic [1:0] {
    ADDR_ZERO,
    ADDR_ONE,
    ADDR_NEXT,
    ADDR_IDX
  } addr_sel_t;

  typedef struct packed {
    logic      store;
    logic      rd;
    addr_sel_t rd_sel;
    logic      cap_prev;
    logic      cap_cur;
    logic      idx_one;
    logic      idx_zero;
    logic      diff;
    logic      mul;
    logic      wb;
    logic      pass_clr;
    logic      pass_inc;
    logic      emit_load;
    logic      clr_cnt;
  } cmd_t;

  typedef struct packed {
    logic short_seq;
    logic last_interior;
    logic pass_done;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/in_place_laplacian_smoother_top.sv
// ----------------------------------------------------------------------------
// in_place_laplacian_smoother_top
// Stores a run of Q16.16 samples, smooths it in place, streams it back out.
// ----------------------------------------------------------------------------
// Samples are taken one beat per clock into a single-port-write, registered-
// read store of MAX_SECTIONS entries; beats past a full store are dropped.
// The beat with tlast starts smoothing: a start state decides whether to
// smooth, then in each pass every interior entry goes through read,
// difference, multiply and write-back on the one store read port and the
// one multiplier. Emission then reads each beat and loads it into the output
// register once that is free; the next run may load while the final beat
// still waits in the output register. No input is taken during the passes or
// emission. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
module in_place_laplacian_smoother_top
  import lis_pkg::*;
#(
  parameter int unsigned MAX_SECTIONS = 64,
  parameter int unsigned VALUE_BITS   = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // sample
  input  logic                                  s_axis_tlast,  // is_last
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((VALUE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,  // smoothed
  output logic                                  m_axis_tlast,  // last_out
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_INDEX_W-1:0]                cfg_index,
  input  logic [CFG_DATA_W-1:0]                 cfg_data
);

  localparam int unsigned DATA_W = ((VALUE_BITS + 7) / 8) * 8;

  cmd_t                  cmd;
  sts_t                  sts;
  logic [VALUE_BITS-1:0] out_value;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = DATA_W'(out_value);

  lis_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_axis_tvalid),
    .in_tready (s_axis_tready),
    .in_tlast  (s_axis_tlast),
    .sts       (sts),
    .cmd       (cmd)
  );

  lis_dpath #(
    .MAX_SECTIONS (MAX_SECTIONS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_sample (s_axis_tdata[VALUE_BITS-1:0]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (out_value),
    .out_last  (m_axis_tlast)
  );

endmodule

FILE: sv/lis_ram.sv
// ----------------------------------------------------------------------------
// lis_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lis_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/lis_ctrl.sv
// ----------------------------------------------------------------------------
// lis_ctrl
// Sequencer: load, smoothing passes entry by entry, then emission.
// ----------------------------------------------------------------------------
module lis_ctrl
  import lis_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_tvalid,
  output logic   in_tready,
  input  logic   in_tlast,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD:  if (in_tvalid && in_tlast) state_next = ST_START;
      ST_START: state_next = sts.short_seq ? ST_E_RD : ST_P_RD0;
      ST_P_RD0: state_next = ST_P_RD1;
      ST_P_RD1: state_next = ST_P_CAP;
      ST_P_CAP: state_next = ST_RD;
      ST_RD:    state_next = ST_DIF;
      ST_DIF:   state_next = ST_MUL;
      ST_MUL:   state_next = ST_WR;
      ST_WR: begin
        if (!sts.last_interior) begin
          state_next = ST_RD;
        end else if (!sts.pass_done) begin
          state_next = ST_P_RD0;
        end else begin
          state_next = ST_E_RD;
        end
      end
      ST_E_RD:  state_next = ST_E_WAIT;
      ST_E_WAIT: begin
        if (sts.out_free) begin
          state_next = sts.emit_last ? ST_LOAD : ST_E_RD;
        end
      end
      default:  state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.rd_sel = ADDR_ZERO;
    in_tready = 1'b0;
    case (state)
      ST_LOAD: begin
        in_tready = 1'b1;
        cmd.store = in_tvalid;
      end
      ST_START: begin
        cmd.idx_zero = 1'b1;
        cmd.pass_clr = 1'b1;
      end
      ST_P_RD0: begin
        cmd.rd     = 1'b1;
        cmd.rd_sel = ADDR_ZERO;
      end
      ST_P_RD1: begin
        cmd.cap_prev = 1'b1;
        cmd.rd       = 1'b1;
        cmd.rd_sel   = ADDR_ONE;
      end
      ST_P_CAP: begin
        cmd.cap_cur = 1'b1;
        cmd.idx_one = 1'b1;
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        cmd.rd_sel = ADDR_NEXT;
      end
      ST_DIF:   cmd.diff = 1'b1;
      ST_MUL:   cmd.mul = 1'b1;
      ST_WR: begin
        cmd.wb = 1'b1;
        if (sts.last_interior && !sts.pass_done) begin
          cmd.pass_inc = 1'b1;
        end
        if (sts.last_interior && sts.pass_done) begin
          cmd.idx_zero = 1'b1;
        end
      end
      ST_E_RD: begin
        cmd.rd     = 1'b1;
        cmd.rd_sel = ADDR_IDX;
      end
      ST_E_WAIT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          cmd.clr_cnt   = sts.emit_last;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // the update chain runs read, difference, multiply, write-back in order
  a_wr_after_mul: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR) |-> ($past(state) == ST_MUL))
    else $error("write-back not preceded by multiply");

endmodule

FILE: sv/lis_dpath.sv
// ----------------------------------------------------------------------------
// lis_dpath
// Sample store, sliding window of three entries, relaxation arithmetic,
// counters, configuration registers and the output register.
// ----------------------------------------------------------------------------
module lis_dpath
  import lis_pkg::*;
#(
  parameter int unsigned MAX_SECTIONS = 64,
  parameter int unsigned VALUE_BITS   = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic [VALUE_BITS-1:0]   in_sample,
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [VALUE_BITS-1:0]   out_value,
  output logic                    out_last
);

  localparam int unsigned AW = $clog2(MAX_SECTIONS);
  localparam int unsigned CW = $clog2(MAX_SECTIONS + 1);
  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned PW = VB + 20;

  logic [CW-1:0]        cnt;
  logic [CW-1:0]        idx;
  logic [3:0]           pass;
  logic [16:0]          weight;
  logic [3:0]           pass_count;

  logic signed [VB-1:0] prev, cur, nxt;
  logic signed [VB+1:0] d;
  logic signed [PW-1:0] prod;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [VB-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [VB-1:0]        ram_rdata;

  logic                 has_room;
  logic [16:0]          w_eff;
  logic signed [17:0]   w_ext;
  logic signed [VB+1:0] d_sum;
  logic signed [PW-1:0] delta;
  logic [VB-1:0]        new_val;
  logic [CW-1:0]        idx_inc;

  assign has_room = (cnt < CW'(MAX_SECTIONS));
  assign idx_inc  = idx + CW'(1);
  assign w_eff    = (weight > WEIGHT_FULL) ? WEIGHT_FULL : weight;
  assign w_ext    = $signed({1'b0, w_eff});

  // twice (mean - x[i]), exact
  assign d_sum = {{2{prev[VB-1]}}, prev} + {{2{ram_rdata[VB-1]}}, ram_rdata}
               - {cur[VB-1], cur, 1'b0};
  // arithmetic shift floors toward minus infinity
  assign delta   = prod >>> 17;
  assign new_val = cur + delta[VB-1:0];

  assign ram_we    = (cmd.store && has_room) || cmd.wb;
  assign ram_waddr = cmd.wb ? idx[AW-1:0] : cnt[AW-1:0];
  assign ram_wdata = cmd.wb ? new_val : in_sample;

  always_comb begin
    case (cmd.rd_sel)
      ADDR_ZERO: ram_raddr = '0;
      ADDR_ONE:  ram_raddr = AW'(1);
      ADDR_NEXT: ram_raddr = idx_inc[AW-1:0];
      ADDR_IDX:  ram_raddr = idx[AW-1:0];
      default:   ram_raddr = '0;
    endcase
  end

  lis_ram #(
    .WIDTH (VB),
    .DEPTH (MAX_SECTIONS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.short_seq     = (cnt < CW'(MIN_SMOOTH_LEN)) || (pass_count == 4'd0);
    sts.last_interior = ({1'b0, idx} + (CW + 1)'(2)) >= {1'b0, cnt};
    sts.pass_done     = ({1'b0, pass} + 5'd1) >= {1'b0, pass_count};
    sts.emit_last     = (idx_inc == cnt);
    sts.out_free      = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      idx        <= '0;
      pass       <= '0;
      out_valid  <= 1'b0;
      weight     <= WEIGHT_RESET;
      pass_count <= PASS_RESET;
    end else begin
      if (cfg_we && cfg_index == REG_SMOOTH_WEIGHT) begin
        weight <= cfg_data;
      end
      if (cfg_we && cfg_index == REG_PASS_COUNT) begin
        pass_count <= cfg_data[3:0];
      end

      if (cmd.clr_cnt) begin
        cnt <= '0;
      end else if (cmd.store && has_room) begin
        cnt <= cnt + CW'(1);
      end

      if (cmd.idx_zero) begin
        idx <= '0;
      end else if (cmd.idx_one) begin
        idx <= CW'(1);
      end else if (cmd.wb || cmd.emit_load) begin
        idx <= idx_inc;
      end

      if (cmd.pass_clr) begin
        pass <= '0;
      end else if (cmd.pass_inc) begin
        pass <= pass + 4'd1;
      end

      if (cmd.emit_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_prev) begin
      prev <= ram_rdata;
    end else if (cmd.wb) begin
      prev <= new_val;
    end
    if (cmd.cap_cur) begin
      cur <= ram_rdata;
    end else if (cmd.wb) begin
      cur <= nxt;
    end
    if (cmd.diff) begin
      nxt <= ram_rdata;
      d   <= d_sum;
    end
    if (cmd.mul) begin
      prod <= d * w_ext;
    end
    if (cmd.emit_load) begin
      out_value <= ram_rdata;
      out_last  <= (idx_inc == cnt);
    end
  end

  // only interior entries are ever rewritten
  a_wb_interior: assert property (@(posedge clk) disable iff (rst)
    cmd.wb |-> (idx != '0) && (({1'b0, idx} + (CW + 1)'(1)) < {1'b0, cnt}))
    else $error("write-back outside the interior");

  // a new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // the marked beat is the one that empties the store count
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_load && sts.emit_last) |=> (cnt == '0) && out_last)
    else $error("final beat did not end the sequence");

endmodule
